// ===== rtl/lew_pkg.sv =====
// Shared types and constants of the masked 3x3 luma erosion block.
// Pixel layout, pipeline operation record, window snapshot and result types.
// No dependencies; every other file of the block but lew_ram uses this package.
package lew_pkg;

    localparam int LUMA_W         = 8;
    localparam int CHROMA_W       = 16;
    localparam int PIX_W          = LUMA_W + CHROMA_W;

    localparam int WIN_ROWS       = 3;
    localparam int WIN_COLS       = 3;
    localparam int WIN_TAPS       = WIN_ROWS * WIN_COLS;
    localparam int MASK_W         = WIN_TAPS;

    localparam int MAX_LINE_WIDTH = 1920;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int ROW_W          = HEIGHT_W;

    localparam int LANE_W         = $clog2(WIN_ROWS);
    localparam int LINE_W         = PIX_W * WIN_ROWS;

    localparam int QUEUE_DEPTH    = 8;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;

    localparam logic [LUMA_W-1:0]   LUMA_TOP       = 8'hFF;
    localparam logic [WIDTH_W-1:0]  WIDTH_LIMIT    = WIDTH_W'(MAX_LINE_WIDTH);
    localparam logic [ROW_W-1:0]    FIRST_MAIN_ROW = ROW_W'(WIN_ROWS / 2);
    localparam logic [MASK_W-1:0]   MASK_RESET     = '1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = WIDTH_W'(1920);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = HEIGHT_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_MASK  = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef logic [LANE_W-1:0] lane_t;

    typedef struct packed {
        logic [CHROMA_W-1:0] chroma;
        logic [LUMA_W-1:0]   luma;
    } pix_t;

    localparam pix_t SCAN_START = '{chroma: '0, luma: LUMA_TOP};

    typedef enum logic [1:0] {
        OP_PRELOAD,
        OP_MAIN,
        OP_FLUSH
    } op_kind_t;

    // One column operation handed from the sequencer to the window stage.
    typedef struct packed {
        logic             valid;
        op_kind_t         kind;
        logic [COL_W-1:0] addr;
        logic             wr_en;
        lane_t            wr_lane;
        pix_t             wr_pix;
        logic             rd_en;
        lane_t            top_lane;
        lane_t            mid_lane;
        logic             top_zero;
        logic             mid_zero;
        logic             result;
        logic             last;
        logic             clear_after;
    } op_t;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        pix_t [WIN_TAPS-1:0]       taps;
    } win_t;

    typedef struct packed {
        logic [LUMA_W-1:0]   luma;
        logic [CHROMA_W-1:0] chroma;
        logic                last;
    } result_t;

endpackage

// ===== rtl/lew_pix_if.sv =====
// Input pixel channel: valid/ready handshake with mode, luma and chroma.
// Depends on lew_pkg for field widths.
interface lew_pix_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [lew_pkg::LUMA_W-1:0]    luma;
    logic [lew_pkg::CHROMA_W-1:0]  chroma;

    modport source (output valid, output mode, output luma, output chroma, input ready);
    modport sink   (input valid, input mode, input luma, input chroma, output ready);
endinterface

// ===== rtl/lew_res_if.sv =====
// Result channel: valid/ready handshake with eroded luma, chroma and run marker.
// Depends on lew_pkg for field widths.
interface lew_res_if;
    logic                          valid;
    logic                          ready;
    logic [lew_pkg::LUMA_W-1:0]    eroded_luma;
    logic [lew_pkg::CHROMA_W-1:0]  eroded_chroma;
    logic                          last_of_run;

    modport source (output valid, output eroded_luma, output eroded_chroma,
                    output last_of_run, input ready);
    modport sink   (input valid, input eroded_luma, input eroded_chroma,
                    input last_of_run, output ready);
endinterface

// ===== rtl/lew_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/lew_seq.sv =====
// Raster sequencer: column/row counters, line-row rotation, per-row fill counts
// and the extra flush column at each main row end. Issues one op per cycle, but only
// while a pixel is accepted or a flush is due. Depends on lew_pkg and lew_pix_if.
module lew_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    lew_pix_if.sink                         pixels,
    input  logic [lew_pkg::WIDTH_W-1:0]     image_width,
    input  logic [lew_pkg::HEIGHT_W-1:0]    image_height,
    input  logic [lew_pkg::QCNT_W-1:0]      queued,
    input  logic [1:0]                      busy,
    output lew_pkg::op_t                    op
);

    logic [lew_pkg::COL_W-1:0]    col_reg, col_next;
    logic [lew_pkg::ROW_W-1:0]    row_reg, row_next;
    logic                         preload_reg, preload_next;
    logic                         flush_reg, flush_next;
    lew_pkg::lane_t               order_reg [lew_pkg::WIN_ROWS];
    lew_pkg::lane_t               order_next [lew_pkg::WIN_ROWS];
    logic [lew_pkg::COL_W-1:0]    fill_reg [lew_pkg::WIN_ROWS];
    logic [lew_pkg::COL_W-1:0]    fill_next [lew_pkg::WIN_ROWS];

    logic [lew_pkg::WIDTH_W-1:0]  w_eff;
    logic [lew_pkg::HEIGHT_W-1:0] h_eff;
    logic [lew_pkg::QCNT_W-1:0]   held_total;
    logic                         room;
    logic                         accept;
    logic                         in_row;
    logic                         col_last;
    logic                         main_live;
    logic                         restart;
    logic [lew_pkg::COL_W-1:0]    col_inc;
    lew_pkg::pix_t                pix_in;

    always_comb
    begin
        if (image_width == '0)
        begin
            w_eff = lew_pkg::WIDTH_W'(1);
        end
        else if (image_width > lew_pkg::WIDTH_LIMIT)
        begin
            w_eff = lew_pkg::WIDTH_LIMIT;
        end
        else
        begin
            w_eff = image_width;
        end
    end

    assign h_eff = (image_height == '0) ? lew_pkg::HEIGHT_W'(1) : image_height;

    // Every accepted item may cause two results, so keep room for both.
    assign held_total = queued + lew_pkg::QCNT_W'(busy) + lew_pkg::QCNT_W'(flush_reg);
    assign room       = held_total <= lew_pkg::QCNT_W'(lew_pkg::QUEUE_DEPTH - 2);
    assign pixels.ready = room && !flush_reg;
    assign accept       = pixels.valid && pixels.ready;

    assign in_row    = col_reg < w_eff;
    assign col_last  = ((lew_pkg::COL_W + 1)'(col_reg) + 1'b1) >= (lew_pkg::COL_W + 1)'(w_eff);
    assign col_inc   = col_reg + 1'b1;
    assign main_live = row_reg < h_eff;
    assign pix_in    = pixels.mode ? '0 : {pixels.chroma, pixels.luma};

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        preload_next = preload_reg;
        flush_next   = 1'b0;
        restart      = 1'b0;
        for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
        begin
            order_next[l] = order_reg[l];
            fill_next[l]  = fill_reg[l];
        end

        op          = '0;
        op.kind     = lew_pkg::OP_MAIN;
        op.addr     = col_reg;
        op.top_lane = order_reg[0];
        op.mid_lane = order_reg[1];
        op.top_zero = col_reg >= fill_reg[order_reg[0]];
        op.mid_zero = col_reg >= fill_reg[order_reg[1]];

        if (flush_reg)
        begin
            // Zero column to the right of the row; closes the row's window.
            op.valid       = 1'b1;
            op.kind        = lew_pkg::OP_FLUSH;
            op.result      = 1'b1;
            op.last        = 1'b1;
            op.clear_after = 1'b1;
        end
        else if (accept)
        begin
            op.valid = 1'b1;
            op.wr_en = in_row;
            if (preload_reg)
            begin
                op.kind    = lew_pkg::OP_PRELOAD;
                op.wr_lane = row_reg[lew_pkg::LANE_W-1:0];
                op.wr_pix  = pix_in;
                if (col_last)
                begin
                    col_next     = '0;
                    preload_next = 1'b0;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
            else
            begin
                op.kind    = lew_pkg::OP_MAIN;
                op.wr_lane = order_reg[lew_pkg::WIN_ROWS-1];
                op.wr_pix  = main_live ? pix_in : '0;
                op.rd_en   = in_row;
                op.result  = col_reg != '0;
                op.last    = !col_last;
                if (col_last)
                begin
                    flush_next = 1'b1;
                    col_next   = '0;
                    for (int l = 0; l < lew_pkg::WIN_ROWS - 1; l++)
                    begin
                        order_next[l] = order_reg[l + 1];
                    end
                    order_next[lew_pkg::WIN_ROWS-1] = order_reg[0];
                    row_next = lew_pkg::ROW_W'(row_reg + 1'b1);
                    if (row_reg >= h_eff)
                    begin
                        restart = 1'b1;
                    end
                end
                else
                begin
                    col_next = col_inc;
                end
            end

            // Rows are always written from column 0 upward, so a count of the
            // written prefix tells which entries hold data and which read as zero.
            for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
            begin
                if (op.wr_en && (op.wr_lane == lew_pkg::LANE_W'(l)) && (col_reg >= fill_reg[l]))
                begin
                    fill_next[l] = col_inc;
                end
            end

            if (restart)
            begin
                for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
                begin
                    order_next[l] = lew_pkg::LANE_W'(l);
                end
                for (int l = 0; l < lew_pkg::WIN_ROWS / 2; l++)
                begin
                    fill_next[l] = '0;
                end
                row_next     = lew_pkg::FIRST_MAIN_ROW;
                preload_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= lew_pkg::FIRST_MAIN_ROW;
            preload_reg <= 1'b1;
            flush_reg   <= 1'b0;
            for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
            begin
                order_reg[l] <= lew_pkg::LANE_W'(l);
                fill_reg[l]  <= '0;
            end
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            preload_reg <= preload_next;
            flush_reg   <= flush_next;
            for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
            begin
                order_reg[l] <= order_next[l];
                fill_reg[l]  <= fill_next[l];
            end
        end
    end

endmodule

// ===== rtl/lew_window.sv =====
// Window stage: read-modify-write of the packed line word, forwarding of the
// previous write, and the sliding 3x3 pixel window with its result snapshot.
// Depends on lew_pkg.
module lew_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lew_pkg::op_t                   op,
    input  logic [lew_pkg::LINE_W-1:0]     ram_rd_data,
    output logic                           ram_wr_en,
    output logic [lew_pkg::COL_W-1:0]      ram_wr_addr,
    output logic [lew_pkg::LINE_W-1:0]     ram_wr_data,
    output logic [1:0]                     busy,
    output lew_pkg::win_t                  snap
);

    lew_pkg::op_t                  op_reg;
    logic                          fwd_valid_reg;
    logic [lew_pkg::COL_W-1:0]     fwd_addr_reg;
    logic [lew_pkg::LINE_W-1:0]    fwd_data_reg;
    lew_pkg::pix_t                 window_reg [lew_pkg::WIN_TAPS];
    lew_pkg::win_t                 snap_reg;

    logic [lew_pkg::LINE_W-1:0]    line;
    logic [lew_pkg::LINE_W-1:0]    merged;
    lew_pkg::pix_t                 lane_pix [lew_pkg::WIN_ROWS];
    lew_pkg::pix_t                 fresh [lew_pkg::WIN_ROWS];
    lew_pkg::pix_t                 shifted [lew_pkg::WIN_TAPS];
    logic                          shift_en;

    // The RAM returns the old word when the previous op wrote the same column.
    assign line = (fwd_valid_reg && (fwd_addr_reg == op_reg.addr)) ? fwd_data_reg : ram_rd_data;

    always_comb
    begin
        for (int l = 0; l < lew_pkg::WIN_ROWS; l++)
        begin
            lane_pix[l] = line[l * lew_pkg::PIX_W +: lew_pkg::PIX_W];
            merged[l * lew_pkg::PIX_W +: lew_pkg::PIX_W] =
                (op_reg.wr_lane == lew_pkg::LANE_W'(l)) ? op_reg.wr_pix : lane_pix[l];
        end
    end

    // New right-hand column: two older rows from memory, newest row is the
    // pixel being stored in this very column.
    always_comb
    begin
        fresh[0] = (op_reg.rd_en && !op_reg.top_zero) ? lane_pix[op_reg.top_lane] : '0;
        fresh[1] = (op_reg.rd_en && !op_reg.mid_zero) ? lane_pix[op_reg.mid_lane] : '0;
        fresh[2] = op_reg.rd_en ? op_reg.wr_pix : '0;
        for (int r = 0; r < lew_pkg::WIN_ROWS; r++)
        begin
            for (int c = 0; c < lew_pkg::WIN_COLS; c++)
            begin
                if (c == lew_pkg::WIN_COLS - 1)
                begin
                    shifted[r * lew_pkg::WIN_COLS + c] = fresh[r];
                end
                else
                begin
                    shifted[r * lew_pkg::WIN_COLS + c] = window_reg[r * lew_pkg::WIN_COLS + c + 1];
                end
            end
        end
    end

    assign shift_en    = op_reg.valid && (op_reg.kind != lew_pkg::OP_PRELOAD);
    assign ram_wr_en   = op_reg.valid && op_reg.wr_en;
    assign ram_wr_addr = op_reg.addr;
    assign ram_wr_data = merged;
    assign busy        = {1'b0, op_reg.valid && op_reg.result} + {1'b0, snap_reg.valid};
    assign snap        = snap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_addr_reg  <= '0;
            fwd_data_reg  <= '0;
            snap_reg      <= '0;
            for (int i = 0; i < lew_pkg::WIN_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            op_reg        <= op;
            fwd_valid_reg <= ram_wr_en;
            fwd_addr_reg  <= op_reg.addr;
            fwd_data_reg  <= merged;
            snap_reg.valid <= shift_en && op_reg.result;
            if (shift_en)
            begin
                snap_reg.last <= op_reg.last;
                for (int i = 0; i < lew_pkg::WIN_TAPS; i++)
                begin
                    snap_reg.taps[i] <= shifted[i];
                    window_reg[i]    <= op_reg.clear_after ? '0 : shifted[i];
                end
            end
        end
    end

endmodule

// ===== rtl/lew_reduce.sv =====
// Masked minimum over the window snapshot (first smallest in row-major order)
// and the result queue that decouples the pipeline from the output channel.
// Depends on lew_pkg and lew_res_if.
module lew_reduce (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lew_pkg::win_t                  snap,
    input  logic [lew_pkg::MASK_W-1:0]     kernel_mask,
    lew_res_if.source                      results,
    output logic [lew_pkg::QCNT_W-1:0]     queued
);

    localparam int CANDS = lew_pkg::WIN_TAPS + 1;

    // Ties keep the left operand, so the earliest pixel in scan order wins.
    function automatic lew_pkg::pix_t pick(input lew_pkg::pix_t a, input lew_pkg::pix_t b);
        return (b.luma < a.luma) ? b : a;
    endfunction

    lew_pkg::pix_t              cand [CANDS];
    lew_pkg::pix_t              lvl1 [CANDS / 2];
    lew_pkg::pix_t              lvl2a, lvl2b, lvl3, best;

    lew_pkg::result_t           queue_mem [lew_pkg::QUEUE_DEPTH];
    lew_pkg::result_t           head;
    logic [lew_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lew_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       push, pop;

    always_comb
    begin
        // The scan starts from full-scale luma with zero chroma; a disabled
        // position behaves exactly like that starting point.
        cand[0] = lew_pkg::SCAN_START;
        for (int i = 0; i < lew_pkg::WIN_TAPS; i++)
        begin
            cand[i + 1] = kernel_mask[i] ? snap.taps[i] : lew_pkg::SCAN_START;
        end
        for (int i = 0; i < CANDS / 2; i++)
        begin
            lvl1[i] = pick(cand[2 * i], cand[2 * i + 1]);
        end
        lvl2a = pick(lvl1[0], lvl1[1]);
        lvl2b = pick(lvl1[2], lvl1[3]);
        lvl3  = pick(lvl2a, lvl2b);
        best  = pick(lvl3, lvl1[4]);
    end

    assign push = snap.valid;
    assign pop  = results.valid && results.ready;
    assign head = queue_mem[rd_ptr_reg];

    assign results.valid         = count_reg != '0;
    assign results.eroded_luma   = head.luma;
    assign results.eroded_chroma = head.chroma;
    assign results.last_of_run   = head.last;
    assign queued                = count_reg;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{luma: best.luma, chroma: best.chroma, last: snap.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/luma_erosion_window_min_core.sv =====
// Masked 3x3 luma erosion core. With an empty result queue, the result an item causes
// passes the op register, the window snapshot register and the queue before it is valid.
// Throughput: one item per cycle while the result queue has room; after the last item of a
// main row the input stalls while the zero border column shifts through the window, which
// moves one column and yields one result per cycle.
// Reset clears counters, row order, window and queue and loads register defaults.
module luma_erosion_window_min_core (
    input  logic                              clk,
    input  logic                              rst_n,
    lew_pix_if.sink                           pixels,
    lew_res_if.source                         results,
    input  logic                              cfg_write,
    input  logic [lew_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lew_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [lew_pkg::MASK_W-1:0]   kernel_mask_reg;
    logic [lew_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [lew_pkg::HEIGHT_W-1:0] image_height_reg;

    lew_pkg::op_t                 op;
    lew_pkg::win_t                snap;
    logic [lew_pkg::QCNT_W-1:0]   queued;
    logic [1:0]                   busy;
    logic                         ram_wr_en;
    logic [lew_pkg::COL_W-1:0]    ram_wr_addr;
    logic [lew_pkg::LINE_W-1:0]   ram_wr_data;
    logic [lew_pkg::LINE_W-1:0]   ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mask_reg  <= lew_pkg::MASK_RESET;
            image_width_reg  <= lew_pkg::WIDTH_RESET;
            image_height_reg <= lew_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lew_pkg::CFG_KERNEL_MASK:
                    kernel_mask_reg <= cfg_data[lew_pkg::MASK_W-1:0];
                lew_pkg::CFG_IMAGE_WIDTH:
                    image_width_reg <= cfg_data[lew_pkg::WIDTH_W-1:0];
                lew_pkg::CFG_IMAGE_HEIGHT:
                    image_height_reg <= cfg_data[lew_pkg::HEIGHT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    lew_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .queued       (queued),
        .busy         (busy),
        .op           (op)
    );

    // One word per column holds that column of all three line rows.
    lew_ram #(
        .WIDTH (lew_pkg::LINE_W),
        .DEPTH (lew_pkg::MAX_LINE_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (op.addr),
        .rd_data (ram_rd_data)
    );

    lew_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .busy        (busy),
        .snap        (snap)
    );

    lew_reduce u_reduce (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap        (snap),
        .kernel_mask (kernel_mask_reg),
        .results     (results),
        .queued      (queued)
    );

endmodule
